/* rtl/core/planar_bitmap_palette_pixel_fetch_unit_assert.svh */
// Assertion macros for the planar bitmap pixel fetch unit.
`ifndef PLANAR_BITMAP_PALETTE_PIXEL_FETCH_UNIT_ASSERT_SVH
`define PLANAR_BITMAP_PALETTE_PIXEL_FETCH_UNIT_ASSERT_SVH

// Condition must hold on every clock edge out of reset.
`define PBPF_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("pixel fetch assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define PBPF_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pixel fetch assertion failed");

`endif

/* rtl/core/pbpf_pkg.sv */
// Shared constants, codes and types of the planar bitmap pixel fetch unit.
`timescale 1ns / 1ps

package pbpf_pkg;

    localparam int BITMAP_BYTES  = 65536;
    localparam int BM_AW         = $clog2(BITMAP_BYTES);
    localparam int PAL_ENTRIES   = 32;
    localparam int PAL_AW        = $clog2(PAL_ENTRIES);
    localparam int GATHER_PLANES = 5;
    localparam int MAX_PLANES    = 15;

    localparam int RB_W     = 9;
    localparam int STRIDE_W = 20;
    localparam int YRB_W    = 19;
    localparam int BASE_W   = 20;
    localparam int OFF_W    = 24;

    localparam logic [1:0] CMD_WR_BITMAP  = 2'd0;
    localparam logic [1:0] CMD_WR_PALETTE = 2'd1;
    localparam logic [1:0] CMD_RENDER     = 2'd2;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_PLANES = 2'd2;

    typedef struct packed {
        logic [10:0] width;
        logic [10:0] height;
        logic [3:0]  planes;
    } cfg_t;

    typedef struct packed {
        logic [1:0]                           cmd;
        logic [15:0]                          addr;
        logic [11:0]                          wdata;
        logic [2:0]                           xbit;
        logic                                 err;
        logic [GATHER_PLANES-1:0][BM_AW-1:0]  raddr;
    } fetch_t;

endpackage

/* rtl/core/pbpf_plane_ram.sv */
// Single-port 8-bit bitmap memory copy with registered read data.
`timescale 1ns / 1ps

module pbpf_plane_ram (
    input  logic                      clk,
    input  logic                      en,
    input  logic                      we,
    input  logic [pbpf_pkg::BM_AW-1:0] addr,
    input  logic [7:0]                wdata,
    output logic [7:0]                rdata
);
    import pbpf_pkg::*;

    logic [7:0] mem [BITMAP_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            else
                rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/pbpf_addr_gen.sv */
// Front pipeline stages: request capture, row offset, per-plane byte offsets and range check.
`timescale 1ns / 1ps

module pbpf_addr_gen (
    input  logic             clk,
    input  logic             rst_n,
    input  pbpf_pkg::cfg_t   cfg,
    input  logic             in_valid,
    input  logic [1:0]       in_cmd,
    input  logic [15:0]      in_addr,
    input  logic [11:0]      in_wdata,
    input  logic [9:0]       in_x,
    input  logic [9:0]       in_y,
    input  logic             en_a,
    input  logic             en_b,
    input  logic             en_c,
    output logic             va,
    output logic             vb,
    output logic             vc,
    output pbpf_pkg::fetch_t fetch
);
    import pbpf_pkg::*;

    // config-derived geometry
    logic [11:0]          width_pad;
    logic [RB_W-1:0]      pitch_next;
    logic [STRIDE_W-1:0]  stride_next;
    logic [RB_W-1:0]      pitch_reg;
    logic [STRIDE_W-1:0]  stride_reg;
    logic [OFF_W-1:0]     plane_off_reg [MAX_PLANES];

    assign width_pad   = {1'b0, cfg.width} + 12'd15;
    assign pitch_next  = {width_pad[11:4], 1'b0};
    assign stride_next = STRIDE_W'(cfg.height) * STRIDE_W'(pitch_next);

    always_ff @(posedge clk)
    begin
        pitch_reg  <= pitch_next;
        stride_reg <= stride_next;
        for (int p = 0; p < MAX_PLANES; p++)
        begin
            plane_off_reg[p] <= OFF_W'(p) * OFF_W'(stride_reg);
        end
    end

    // stage A
    logic        va_reg;
    logic [1:0]  a_cmd_reg;
    logic [15:0] a_addr_reg;
    logic [11:0] a_wdata_reg;
    logic [9:0]  a_x_reg;
    logic [9:0]  a_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else if (en_a)
            va_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            a_cmd_reg   <= in_cmd;
            a_addr_reg  <= in_addr;
            a_wdata_reg <= in_wdata;
            a_x_reg     <= in_x;
            a_y_reg     <= in_y;
        end
    end

    // stage B: row offset and coordinate check
    logic             vb_reg;
    logic [1:0]       b_cmd_reg;
    logic [15:0]      b_addr_reg;
    logic [11:0]      b_wdata_reg;
    logic [9:0]       b_x_reg;
    logic [YRB_W-1:0] b_yrb_reg;
    logic             b_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else if (en_b)
            vb_reg <= va_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            b_cmd_reg   <= a_cmd_reg;
            b_addr_reg  <= a_addr_reg;
            b_wdata_reg <= a_wdata_reg;
            b_x_reg     <= a_x_reg;
            b_yrb_reg   <= YRB_W'(a_y_reg) * YRB_W'(pitch_reg);
            b_err_reg   <= ({1'b0, a_x_reg} >= cfg.width) || ({1'b0, a_y_reg} >= cfg.height);
        end
    end

    // stage C: plane offsets
    logic [BASE_W-1:0]     base;
    logic [OFF_W-1:0]      off [MAX_PLANES];
    logic [MAX_PLANES-1:0] oor;
    pbpf_pkg::fetch_t      fetch_next;
    logic                  vc_reg;
    pbpf_pkg::fetch_t      fetch_reg;

    assign base = BASE_W'(b_yrb_reg) + BASE_W'(b_x_reg[9:3]);

    always_comb
    begin
        for (int p = 0; p < MAX_PLANES; p++)
        begin
            off[p] = plane_off_reg[p] + OFF_W'(base);
            oor[p] = (off[p] >= OFF_W'(BITMAP_BYTES)) && (4'(p) < cfg.planes);
        end
        fetch_next.cmd   = b_cmd_reg;
        fetch_next.addr  = b_addr_reg;
        fetch_next.wdata = b_wdata_reg;
        fetch_next.xbit  = b_x_reg[2:0];
        fetch_next.err   = b_err_reg || (|oor);
        for (int p = 0; p < GATHER_PLANES; p++)
        begin
            fetch_next.raddr[p] = off[p][BM_AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vc_reg <= 1'b0;
        else if (en_c)
            vc_reg <= vb_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en_c)
            fetch_reg <= fetch_next;
    end

    assign va    = va_reg;
    assign vb    = vb_reg;
    assign vc    = vc_reg;
    assign fetch = fetch_reg;

endmodule

/* rtl/core/pbpf_color_out.sv */
// Back pipeline stages: plane bit gather, palette store and lookup, ARGB expansion.
`timescale 1ns / 1ps

module pbpf_color_out (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pbpf_pkg::cfg_t                       cfg,
    input  logic                                 vc,
    input  pbpf_pkg::fetch_t                     fetch,
    input  logic [pbpf_pkg::GATHER_PLANES-1:0][7:0] plane_byte,
    input  logic                                 en_d,
    input  logic                                 en_e,
    output logic                                 vd,
    output logic                                 ve,
    output logic [31:0]                          argb,
    output logic [4:0]                           color_index,
    output logic                                 range_error
);
    import pbpf_pkg::*;

    logic [11:0] pal_reg [PAL_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (en_d && vc && (fetch.cmd == CMD_WR_PALETTE))
            pal_reg[fetch.addr[PAL_AW-1:0]] <= fetch.wdata;
    end

    // stage D: plane bytes arrive from the memories
    logic       vd_reg;
    logic [2:0] d_xbit_reg;
    logic       d_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vd_reg <= 1'b0;
        else if (en_d)
            vd_reg <= vc && (fetch.cmd == CMD_RENDER);
    end

    always_ff @(posedge clk)
    begin
        if (en_d)
        begin
            d_xbit_reg <= fetch.xbit;
            d_err_reg  <= fetch.err;
        end
    end

    logic [PAL_AW-1:0] ci;
    logic [2:0]        bit_sel;
    logic [11:0]       color;

    assign bit_sel = 3'd7 - d_xbit_reg;

    always_comb
    begin
        for (int p = 0; p < GATHER_PLANES; p++)
        begin
            ci[p] = plane_byte[p][bit_sel] && (4'(p) < cfg.planes);
        end
    end

    assign color = pal_reg[ci];

    // stage E: output register
    logic        ve_reg;
    logic [31:0] argb_reg;
    logic [4:0]  ci_reg;
    logic        err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ve_reg <= 1'b0;
        else if (en_e)
            ve_reg <= vd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en_e)
        begin
            err_reg <= d_err_reg;
            if (d_err_reg)
            begin
                argb_reg <= 32'd0;
                ci_reg   <= 5'd0;
            end
            else
            begin
                // a nibble times 17 is the nibble repeated
                argb_reg <= {8'hFF, color[11:8], color[11:8], color[7:4], color[7:4],
                             color[3:0], color[3:0]};
                ci_reg   <= ci;
            end
        end
    end

    assign vd          = vd_reg;
    assign ve          = ve_reg;
    assign argb        = argb_reg;
    assign color_index = ci_reg;
    assign range_error = err_reg;

endmodule

/* rtl/core/planar_bitmap_palette_pixel_fetch_unit.sv */
// Planar bitmap pixel fetch unit top level: config registers, bitmap memories, pipeline control.
`timescale 1ns / 1ps

// Takes one request per clock through a five-stage pipeline: capture, row offset,
// plane offsets and range check, bitmap read, palette lookup into the output register.
// A render result leaves through the stage E output register once accepted; write requests
// give no result. The bitmap is held in five identical single-port memory copies,
// one per color-index bit, so all gathered plane bytes are read in one access; every
// bitmap write goes to all copies. Writes take effect in request order, so a render
// accepted right after a write sees it. Memory and palette have no reset and no
// clearing pass. The pipeline stalls only from the output side, and bubbles close up.
// Config must be written by the user only while no request is in flight; the block does not enforce this.
module planar_bitmap_palette_pixel_fetch_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // address[15:0], write_data[27:16], pixel_x[37:28], pixel_y[47:38]
    input  logic [1:0]  s_tuser,  // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // pixel_argb[31:0], color_index[36:32], zero[39:37]
    output logic        m_tuser,  // range_error[0]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);
    import pbpf_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= 11'd320;
            cfg_reg.height <= 11'd200;
            cfg_reg.planes <= 4'd5;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  cfg_reg.width  <= cfg_data;
                CFG_HEIGHT: cfg_reg.height <= cfg_data;
                CFG_PLANES: cfg_reg.planes <= cfg_data[3:0];
                default:    ;
            endcase
        end
    end

    logic   va, vb, vc, vd, ve;
    logic   en_a, en_b, en_c, en_d, en_e;
    fetch_t fetch;

    assign en_e = !ve || m_tready;
    assign en_d = !vd || en_e;
    assign en_c = !vc || en_d;
    assign en_b = !vb || en_c;
    assign en_a = !va || en_b;

    assign s_tready = en_a;

    pbpf_addr_gen u_addr_gen (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_cmd   (s_tuser),
        .in_addr  (s_tdata[15:0]),
        .in_wdata (s_tdata[27:16]),
        .in_x     (s_tdata[37:28]),
        .in_y     (s_tdata[47:38]),
        .en_a     (en_a),
        .en_b     (en_b),
        .en_c     (en_c),
        .va       (va),
        .vb       (vb),
        .vc       (vc),
        .fetch    (fetch)
    );

    logic                          ram_we;
    logic                          ram_en;
    logic [GATHER_PLANES-1:0][7:0] plane_byte;

    assign ram_we = fetch.cmd == CMD_WR_BITMAP;
    assign ram_en = en_d && vc && (ram_we || (fetch.cmd == CMD_RENDER));

    for (genvar g = 0; g < GATHER_PLANES; g++)
    begin : g_plane
        pbpf_plane_ram u_ram (
            .clk   (clk),
            .en    (ram_en),
            .we    (ram_we),
            .addr  (ram_we ? fetch.addr[BM_AW-1:0] : fetch.raddr[g]),
            .wdata (fetch.wdata[7:0]),
            .rdata (plane_byte[g])
        );
    end

    logic [31:0] argb;
    logic [4:0]  color_index;
    logic        range_error;

    pbpf_color_out u_color_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .vc          (vc),
        .fetch       (fetch),
        .plane_byte  (plane_byte),
        .en_d        (en_d),
        .en_e        (en_e),
        .vd          (vd),
        .ve          (ve),
        .argb        (argb),
        .color_index (color_index),
        .range_error (range_error)
    );

    assign m_tvalid = ve;
    assign m_tdata  = {3'b000, color_index, argb};
    assign m_tuser  = range_error;

`include "planar_bitmap_palette_pixel_fetch_unit_assert.svh"

    `PBPF_ASSERT_IMPLY(a_err_zero, m_tvalid && m_tuser, m_tdata == 40'd0)
    `PBPF_ASSERT_IMPLY(a_ok_opaque, m_tvalid && !m_tuser, m_tdata[31:24] == 8'hFF)
    `PBPF_ASSERT_IMPLY(a_stall_full, !s_tready, va && vb && vc && vd && ve && !m_tready)

endmodule

/* test/tb_planar_bitmap_palette_pixel_fetch_unit.sv */
// Testbench for the planar bitmap palette pixel fetch unit: random requests, self-checking.
`timescale 1ns / 1ps

module tb_planar_bitmap_palette_pixel_fetch_unit;
    import pbpf_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  cmd;
        logic [15:0] addr;
        logic [11:0] wdata;
        logic [9:0]  x;
        logic [9:0]  y;
    } pix_req_t;

    typedef struct {
        logic [31:0] argb;
        logic [4:0]  index;
        logic        range_err;
    } pixel_t;

    bit          clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // address[15:0], write_data[27:16], pixel_x[37:28], pixel_y[47:38]
    logic [1:0]  s_tuser = CMD_WR_BITMAP;  // command[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;   // pixel_argb[31:0], color_index[36:32], zero[39:37]
    logic        m_tuser;   // range_error[0]
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_WIDTH;
    logic [10:0] cfg_data = '0;

    pix_req_t    pixel_req_queue[$];
    pixel_t      expected_pixels[$];
    pix_req_t    offered;
    pixel_t      want;
    cfg_t        cfg_now = '{11'd320, 11'd200, 4'd5};
    logic [7:0]  bitmap_mem [0:BITMAP_BYTES-1];
    logic [11:0] palette_mem [0:PAL_ENTRIES-1];
    bit          bm_written [0:BITMAP_BYTES-1];

    bit idle_on = 1'b1;
    bit req_taken = 1'b0;
    bit hold_start = 1'b0;
    bit hold_on = 1'b0;
    int gap_left = 0;
    int stall_left = 0;
    int made = 0;
    int errors = 0;
    int accepted = 0;
    int pixels_checked = 0;
    int pixels_out_of_range = 0;
    int settings_used = 1;

    planar_bitmap_palette_pixel_fetch_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("tb_planar_bitmap_palette_pixel_fetch_unit: done, errors");
        $finish;
    end

    // long receiver hold-off so the pipeline backs up into the input
    initial
    begin
        wait (hold_start);
        @(posedge clk);
        hold_on = 1'b1;
        repeat (300) @(posedge clk);
        hold_on = 1'b0;
    end

    function automatic longint plane_offset(int pl, logic [9:0] x, logic [9:0] y);
        longint pitch;
        pitch = ((longint'(cfg_now.width) + 15) / 16) * 2;
        return longint'(pl) * longint'(cfg_now.height) * pitch
             + longint'(y) * pitch + longint'(x >> 3);
    endfunction

    function automatic void apply_request(pix_req_t r);
        pixel_t      px;
        logic [15:0] gathered;
        logic [11:0] color;
        longint      off;
        bit          err;
        int          pl;
        case (r.cmd)
            CMD_WR_BITMAP:  bitmap_mem[r.addr] = r.wdata[7:0];
            CMD_WR_PALETTE: palette_mem[r.addr[4:0]] = r.wdata;
            CMD_RENDER:
            begin
                err = (r.x >= cfg_now.width) || (r.y >= cfg_now.height);
                gathered = '0;
                for (pl = 0; pl < cfg_now.planes && !err; pl++)
                begin
                    off = plane_offset(pl, r.x, r.y);
                    if (off >= BITMAP_BYTES)
                        err = 1'b1;
                    else
                        gathered[pl] = bitmap_mem[off][3'd7 - r.x[2:0]];
                end
                if (err)
                begin
                    px.argb = '0;
                    px.index = '0;
                    px.range_err = 1'b1;
                end
                else
                begin
                    px.index = gathered[4:0];
                    color = palette_mem[px.index];
                    px.argb = {8'hFF, 8'(color[11:8]) * 8'd17, 8'(color[7:4]) * 8'd17,
                               8'(color[3:0]) * 8'd17};
                    px.range_err = 1'b0;
                end
                expected_pixels.push_back(px);
            end
            default: ;
        endcase
    endfunction

    task automatic push_item(logic [1:0] cmd, logic [15:0] addr, logic [11:0] wdata,
                             logic [9:0] x, logic [9:0] y);
        pix_req_t r;
        r = '{cmd, addr, wdata, x, y};
        pixel_req_queue.push_back(r);
        if (cmd == CMD_WR_BITMAP)
            bm_written[addr] = 1'b1;
        if (cmd != CMD_UNUSED)
            made++;
    endtask

    // loads every plane byte the pixel will read first, unless already loaded and no refresh is asked
    task automatic queue_render(logic [9:0] x, logic [9:0] y, bit refresh);
        longint off;
        int     pl;
        if (x < cfg_now.width && y < cfg_now.height)
        begin
            for (pl = 0; pl < cfg_now.planes; pl++)
            begin
                off = plane_offset(pl, x, y);
                if (off >= BITMAP_BYTES)
                    break;
                if (refresh || !bm_written[off])
                    push_item(CMD_WR_BITMAP, 16'(off), 12'($urandom_range(4095, 0)),
                              10'($urandom), 10'($urandom));
            end
        end
        push_item(CMD_RENDER, 16'($urandom), 12'($urandom), x, y);
    endtask

    task automatic add_random_request();
        int pick;
        int lim_x;
        int lim_y;
        logic [9:0] x;
        logic [9:0] y;
        pick = $urandom_range(99, 0);
        if (pick < 55 || pick >= 93)
        begin
            lim_x = cfg_now.width > 1024 ? 1024 : int'(cfg_now.width);
            lim_y = cfg_now.height > 1024 ? 1024 : int'(cfg_now.height);
            if ($urandom_range(2, 0) == 0)
            begin
                lim_x = lim_x > 24 ? 24 : lim_x;
                lim_y = lim_y > 6 ? 6 : lim_y;
            end
            if (lim_x > 0 && lim_y > 0 && $urandom_range(3, 0) != 0)
            begin
                x = 10'($urandom_range(lim_x - 1, 0));
                y = 10'($urandom_range(lim_y - 1, 0));
            end
            else
            begin
                x = 10'($urandom_range(1023, 0));
                y = 10'($urandom_range(1023, 0));
            end
            queue_render(x, y, pick >= 93);
        end
        else if (pick < 75)
            push_item(CMD_WR_BITMAP, 16'($urandom), 12'($urandom), 10'($urandom), 10'($urandom));
        else if (pick < 88)
            push_item(CMD_WR_PALETTE, 16'($urandom), 12'($urandom), 10'($urandom),
                      10'($urandom));
        else
            push_item(CMD_UNUSED, 16'($urandom), 12'($urandom), 10'($urandom), 10'($urandom));
    endtask

    task automatic fill_random(int n);
        int start;
        start = made;
        while (made - start < n)
            add_random_request();
    endtask

    task automatic wait_idle();
        while (pixel_req_queue.size() != 0 || s_tvalid || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic run_phase(logic [10:0] w, logic [10:0] h, logic [3:0] p, int n,
                             bit idle, bit squeeze);
        wait_idle();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_WIDTH;
        cfg_data <= w;
        @(negedge clk);
        cfg_index <= CFG_HEIGHT;
        cfg_data <= h;
        @(negedge clk);
        cfg_index <= CFG_PLANES;
        cfg_data <= 11'(p);
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_now = '{w, h, p};
        settings_used++;
        @(posedge clk);
        idle_on = idle;
        if (squeeze)
            hold_start = 1'b1;
        fill_random(n);
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (!s_tvalid || req_taken)
        begin
            req_taken = 1'b0;
            if (gap_left != 0)
            begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (idle_on && $urandom_range(9, 0) == 0)
            begin
                s_tvalid <= 1'b0;
                gap_left <= $urandom_range(11, 0);
            end
            else if (pixel_req_queue.size() != 0)
            begin
                offered = pixel_req_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {offered.y, offered.x, offered.wdata, offered.addr};
                s_tuser <= offered.cmd;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        if (hold_on)
            m_tready <= 1'b0;
        else if (stall_left != 0)
        begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(9, 0) == 0)
        begin
            m_tready <= 1'b0;
            stall_left <= $urandom_range(11, 0);
        end
        else
            m_tready <= 1'b1;
    end

    // monitor: checks results, then predicts from accepted requests
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected pixel: argb %h index %0d err %0d",
                                 m_tdata[31:0], m_tdata[36:32], m_tuser);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    pixels_checked++;
                    if (want.range_err)
                        pixels_out_of_range++;
                    if (m_tdata[31:0] !== want.argb || m_tdata[36:32] !== want.index
                        || m_tuser !== want.range_err || m_tdata[39:37] !== 3'b000)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("pixel mismatch: expected argb %h index %0d err %0d, %s",
                                     want.argb, want.index, want.range_err,
                                     $sformatf("got argb %h index %0d err %0d pad %b",
                                               m_tdata[31:0], m_tdata[36:32], m_tuser,
                                               m_tdata[39:37]));
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                apply_request(offered);
                req_taken = 1'b1;
                accepted++;
            end
        end
    end

    initial
    begin
        int i;
        foreach (bitmap_mem[k])
            bitmap_mem[k] = '0;
        foreach (palette_mem[k])
            palette_mem[k] = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // palette load, random high address bits to exercise the index mask
        for (i = 0; i < PAL_ENTRIES; i++)
            push_item(CMD_WR_PALETTE, {11'($urandom), 5'(i)},
                      i == 0 ? 12'h000 : (i == PAL_ENTRIES - 1 ? 12'hFFF : 12'($urandom)),
                      10'($urandom), 10'($urandom));
        push_item(CMD_WR_BITMAP, 16'h0000, 12'hFFF, 10'd0, 10'd0);
        push_item(CMD_WR_BITMAP, 16'hFFFF, 12'h0A5, 10'd1023, 10'd1023);
        queue_render(10'd0, 10'd0, 1'b0);
        queue_render(10'd7, 10'd0, 1'b0);
        queue_render(10'd319, 10'd199, 1'b0);
        queue_render(10'd320, 10'd0, 1'b0);
        queue_render(10'd0, 10'd200, 1'b0);
        queue_render(10'd1023, 10'd1023, 1'b0);
        push_item(CMD_UNUSED, 16'hFFFF, 12'hFFF, 10'd1023, 10'd1023);
        queue_render(10'd0, 10'd0, 1'b1);
        fill_random(200);

        run_phase(11'd16, 11'd4, 4'd8, 200, 1'b1, 1'b0);
        run_phase(11'd1024, 11'd1024, 4'd1, 200, 1'b1, 1'b0);
        run_phase(11'd1, 11'd1, 4'd15, 150, 1'b1, 1'b0);
        run_phase(11'd0, 11'd0, 4'd0, 40, 1'b1, 1'b0);
        run_phase(11'd2047, 11'd2047, 4'd3, 150, 1'b1, 1'b0);
        run_phase(11'd40, 11'd30, 4'd0, 120, 1'b1, 1'b0);
        run_phase(11'd100, 11'd900, 4'd6, 250, 1'b1, 1'b1);
        run_phase(11'd64, 11'd32, 4'd5, 200, 1'b0, 1'b0);
        wait_idle();
        repeat (20) @(posedge clk);

        $display("covered %0d requests over %0d geometry settings", accepted, settings_used);
        $display("%0d pixels compared, %0d of them out of range; %0d mismatches",
                 pixels_checked, pixels_out_of_range, errors);
        if (errors == 0)
            $display("tb_planar_bitmap_palette_pixel_fetch_unit: done, clean");
        else
            $display("tb_planar_bitmap_palette_pixel_fetch_unit: done, errors");
        $finish;
    end

endmodule
